// ===== rtl/core/sha512_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 core package
// Shared sizes, item and control types, the round constant table, the
// initial hash value and the SHA-512 bit-mixing functions.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned WCNT_W      = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);
  localparam int unsigned IDX_W       = $clog2(HASH_WORDS);

  localparam logic [WCNT_W-1:0]  LAST_WORD  = WCNT_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(HASH_WORDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t hash_t [HASH_WORDS];

  // One message word with its framing flags.
  typedef struct packed {
    logic [63:0] message_word;
    logic        new_message;
    logic        final_block;
  } in_item_t;

  // One word of the digest.
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  // Controls for the schedule window.
  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  // Controls for the round unit.
  typedef struct packed {
    logic init;
    logic step;
  } round_ctrl_t;

  localparam hash_t INIT_HASH = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // Compression function mixers.
  function automatic word_t big_sigma0(input word_t x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  // Message schedule mixers.
  function automatic word_t small_sigma0(input word_t x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha512_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 message schedule window
// Sixteen-word shift line. Message words shift in during loading; each round
// shifts once and appends the next expanded schedule word. The oldest word
// is the round's schedule word.
// ----------------------------------------------------------------------------
module sha512_sched (
  input  wire                      clk_i,
  input  sha512_pkg::sched_ctrl_t  ctrl_i,
  input  sha512_pkg::word_t        load_word_i,
  output sha512_pkg::word_t        wt_o
);

  sha512_pkg::word_t win_q [sha512_pkg::BLOCK_WORDS];
  sha512_pkg::word_t win_d [sha512_pkg::BLOCK_WORDS];
  sha512_pkg::word_t next_word;

  // Next schedule word from the window taps.
  assign next_word = sha512_pkg::small_sigma1(win_q[14]) + win_q[9]
                   + sha512_pkg::small_sigma0(win_q[1]) + win_q[0];

  // Shift by one and append the loaded or expanded word at the young end.
  always_comb begin
    for (int i = 0; i < sha512_pkg::BLOCK_WORDS - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[sha512_pkg::BLOCK_WORDS-1] = ctrl_i.load ? load_word_i : next_word;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.step) begin
      win_q <= win_d;
    end
  end

  assign wt_o = win_q[0];

endmodule
`default_nettype wire

// ===== rtl/core/sha512_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 round unit
// Holds the working variables a..h and performs one compression round per
// step. Init loads the variables from the chaining hash.
// ----------------------------------------------------------------------------
module sha512_round (
  input  wire                      clk_i,
  input  sha512_pkg::round_ctrl_t  ctrl_i,
  input  sha512_pkg::hash_t        hash_i,
  input  sha512_pkg::word_t        wt_i,
  input  sha512_pkg::word_t        k_i,
  output sha512_pkg::hash_t        vars_o
);

  sha512_pkg::hash_t vars_q;
  sha512_pkg::hash_t vars_d;
  sha512_pkg::word_t t1;
  sha512_pkg::word_t t2;

  // Round sums.
  assign t1 = vars_q[7] + sha512_pkg::big_sigma1(vars_q[4])
            + sha512_pkg::choose(vars_q[4], vars_q[5], vars_q[6]) + k_i + wt_i;
  assign t2 = sha512_pkg::big_sigma0(vars_q[0])
            + sha512_pkg::majority(vars_q[0], vars_q[1], vars_q[2]);

  // Load the chaining hash on init; otherwise rotate the variables and insert the two new values.
  always_comb begin
    if (ctrl_i.init) begin
      vars_d = hash_i;
    end else begin
      vars_d[0] = t1 + t2;
      vars_d[1] = vars_q[0];
      vars_d[2] = vars_q[1];
      vars_d[3] = vars_q[2];
      vars_d[4] = vars_q[3] + t1;
      vars_d[5] = vars_q[4];
      vars_d[6] = vars_q[5];
      vars_d[7] = vars_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init || ctrl_i.step) begin
      vars_q <= vars_d;
    end
  end

  assign vars_o = vars_q;

endmodule
`default_nettype wire

// ===== rtl/core/sha512_block_hash_core.sv =====
`default_nettype none
// Timing: the sixteenth word of a block starts the rounds, then the
// chaining add; a final block's digest words follow the chaining add.
// Throughput: words of a block are taken one per cycle while loading; the
// input is stalled during the rounds, the add and the digest output. The
// round unit runs one round per cycle; output stall holds the digest words.
// Reset: chaining hash to the SHA-512 initial value, sequencer and counters
// to zero; the schedule window is not cleared.
// ----------------------------------------------------------------------------
// SHA-512 block hash core
// Collects padded message words, runs the SHA-512 compression on each full
// block with one shared round unit, and emits the digest after a final block.
// ----------------------------------------------------------------------------
module sha512_block_hash_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  sha512_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output sha512_pkg::out_item_t  out_item_o
);

  sha512_pkg::state_e                 state_q, state_d;
  logic [sha512_pkg::WCNT_W-1:0]      word_count_q;
  logic [sha512_pkg::ROUND_W-1:0]     round_q;
  logic [sha512_pkg::IDX_W-1:0]       out_idx_q;
  logic                               final_q;
  sha512_pkg::hash_t                  hash_q, hash_d;
  sha512_pkg::hash_t                  vars;
  sha512_pkg::word_t                  wt;
  sha512_pkg::sched_ctrl_t            sched_ctrl;
  sha512_pkg::round_ctrl_t            round_ctrl;
  logic                               in_acc;
  logic                               out_acc;
  logic                               block_done;
  logic                               load_iv;
  logic                               add_hash;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign block_done = in_acc && (word_count_q == sha512_pkg::LAST_WORD);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha512_pkg::S_LOAD: begin
        if (block_done) state_d = sha512_pkg::S_ROUND;
      end
      sha512_pkg::S_ROUND: begin
        if (round_q == sha512_pkg::LAST_ROUND) state_d = sha512_pkg::S_ADD;
      end
      sha512_pkg::S_ADD: begin
        state_d = final_q ? sha512_pkg::S_OUT : sha512_pkg::S_LOAD;
      end
      sha512_pkg::S_OUT: begin
        if (out_acc && (out_idx_q == sha512_pkg::LAST_IDX)) state_d = sha512_pkg::S_LOAD;
      end
      default: state_d = sha512_pkg::S_LOAD;
    endcase
  end

  // Sequencer outputs. The input is never stalled while loading, so a valid
  // word there is an accepted word.
  always_comb begin
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    sched_ctrl      = '0;
    round_ctrl      = '0;
    load_iv         = 1'b0;
    add_hash        = 1'b0;
    unique case (state_q)
      sha512_pkg::S_LOAD: begin
        in_stall_o      = 1'b0;
        sched_ctrl.load = in_valid_i;
        round_ctrl.init = in_valid_i && (word_count_q == sha512_pkg::LAST_WORD);
        load_iv         = in_valid_i && (word_count_q == '0) && in_item_i.new_message;
      end
      sha512_pkg::S_ROUND: begin
        sched_ctrl.step = 1'b1;
        round_ctrl.step = 1'b1;
      end
      sha512_pkg::S_ADD: begin
        add_hash = 1'b1;
      end
      sha512_pkg::S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Chaining hash: initial value at a new message, sum after a block.
  always_comb begin
    for (int i = 0; i < sha512_pkg::HASH_WORDS; i++) begin
      if (load_iv) begin
        hash_d[i] = sha512_pkg::INIT_HASH[i];
      end else if (add_hash) begin
        hash_d[i] = hash_q[i] + vars[i];
      end else begin
        hash_d[i] = hash_q[i];
      end
    end
  end

  // Control registers and chaining hash.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sha512_pkg::S_LOAD;
      word_count_q <= '0;
      round_q      <= '0;
      out_idx_q    <= '0;
      final_q      <= 1'b0;
      hash_q       <= sha512_pkg::INIT_HASH;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      if (in_acc) begin
        word_count_q <= word_count_q + 1'b1;
      end
      if (block_done) begin
        final_q <= in_item_i.final_block;
      end
      if (state_q == sha512_pkg::S_ROUND) begin
        round_q <= (round_q == sha512_pkg::LAST_ROUND) ? '0 : round_q + 1'b1;
      end
      if (out_acc) begin
        out_idx_q <= out_idx_q + 1'b1;
      end
    end
  end

  sha512_sched u_sched (
    .clk_i       (clk_i),
    .ctrl_i      (sched_ctrl),
    .load_word_i (in_item_i.message_word),
    .wt_o        (wt)
  );

  sha512_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .hash_i (hash_q),
    .wt_i   (wt),
    .k_i    (sha512_pkg::ROUND_K[round_q]),
    .vars_o (vars)
  );

  // Digest item from the chaining hash.
  assign out_item_o.digest_word  = hash_q[out_idx_q];
  assign out_item_o.digest_index = out_idx_q;
  assign out_item_o.last_word    = (out_idx_q == sha512_pkg::LAST_IDX);

  // The last word of a block starts the rounds from round zero.
  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_done |=> (state_q == sha512_pkg::S_ROUND) && (round_q == '0))
    else $error("rounds did not start after the last word of a block");

  // The final round is followed by the chaining add.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha512_pkg::S_ROUND) && (round_q == sha512_pkg::LAST_ROUND)
      |=> state_q == sha512_pkg::S_ADD)
    else $error("chaining add missing after the last round");

  // The round counter rests at zero outside the round phase.
  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sha512_pkg::S_ROUND) |-> (round_q == '0))
    else $error("round counter not at zero outside the rounds");

  // After the last digest word the block takes words again from a fresh block.
  a_digest_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.last_word
      |=> (state_q == sha512_pkg::S_LOAD) && (word_count_q == '0) && (out_idx_q == '0))
    else $error("digest output did not end cleanly");

  // Digest words only follow a block flagged as final.
  a_digest_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> final_q)
    else $error("digest word without a final block");

endmodule
`default_nettype wire
